### design/spkh_pkg.sv
// ----------------------------------------------------------------------------
// spkh_pkg
// Shared types, constants and helper functions for the long-path 128-bit
// hash unit: job descriptors, queue request and status groups, rotate tables.
// ----------------------------------------------------------------------------
package spkh_pkg;

    localparam int unsigned LANE_COUNT = 12;

    typedef logic [63:0] lane_t;
    typedef logic [LANE_COUNT-1:0][63:0] block_t;

    localparam lane_t SEED_CONST = 64'hdeadbeefdeadbeef;

    localparam logic [3:0] LAST_SLOT = 4'd11;
    localparam logic [6:0] FULL_BLOCK_BYTES = 7'd96;
    localparam logic [3:0] WORD_BYTES = 4'd8;

    // configuration register indexes
    localparam logic [0:0] REG_SEED_LOW = 1'b0;
    localparam logic [0:0] REG_SEED_HIGH = 1'b1;

    // what the back end does with one queued block
    typedef enum logic [1:0] {
        JOB_MIX,
        JOB_LAST,
        JOB_LAST_FULL
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       first;
        logic [3:0] last_slot;
        logic [6:0] rem;
    } job_t;

    // front end -> queue
    typedef struct packed {
        logic       wr_en;
        logic [3:0] slot;
        logic       commit;
        job_t       desc;
    } fe_req_t;

    // back end -> queue
    typedef struct packed {
        logic       pop;
        logic       rd_next;
        logic [3:0] rd_slot;
    } be_req_t;

    // queue -> back end
    typedef struct packed {
        logic head_valid;
        job_t head_desc;
        logic next_valid;
        job_t next_desc;
    } q_stat_t;

    function automatic lane_t rotl(input lane_t x, input logic [5:0] r);
        logic [127:0] dbl;
        dbl = {x, x} << r;
        return dbl[127:64];
    endfunction

    function automatic logic [5:0] mix_rot(input logic [3:0] i);
        logic [5:0] r;
        unique case (i)
            4'd0:    r = 6'd11;
            4'd1:    r = 6'd32;
            4'd2:    r = 6'd43;
            4'd3:    r = 6'd31;
            4'd4:    r = 6'd17;
            4'd5:    r = 6'd28;
            4'd6:    r = 6'd39;
            4'd7:    r = 6'd57;
            4'd8:    r = 6'd55;
            4'd9:    r = 6'd54;
            4'd10:   r = 6'd22;
            4'd11:   r = 6'd46;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] end_rot(input logic [3:0] i);
        logic [5:0] r;
        unique case (i)
            4'd0:    r = 6'd44;
            4'd1:    r = 6'd15;
            4'd2:    r = 6'd34;
            4'd3:    r = 6'd21;
            4'd4:    r = 6'd38;
            4'd5:    r = 6'd33;
            4'd6:    r = 6'd10;
            4'd7:    r = 6'd13;
            4'd8:    r = 6'd38;
            4'd9:    r = 6'd53;
            4'd10:   r = 6'd42;
            4'd11:   r = 6'd54;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

### design/spkh_front.sv
// ----------------------------------------------------------------------------
// spkh_front
// Accepts message words, masks the last one, counts words in the block and
// hands finished blocks to the queue with a job descriptor.
// ----------------------------------------------------------------------------
module spkh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [63:0]        word_data,
    input  logic [3:0]         valid_bytes,
    input  logic               last_word,
    output spkh_pkg::fe_req_t  fe,
    output spkh_pkg::lane_t    wr_data
);

    logic [3:0] slot_reg;
    logic [3:0] slot_next;
    logic       first_reg;
    logic       first_next;
    logic [3:0] nbytes;
    logic [6:0] rem;
    logic       block_full;

    always_comb
    begin
        nbytes = (valid_bytes > spkh_pkg::WORD_BYTES) ? spkh_pkg::WORD_BYTES : valid_bytes;
        wr_data = word_data;
        if (last_word)
        begin
            for (int b = 0; b < 8; b++)
            begin
                if (4'(b) >= nbytes)
                begin
                    wr_data[b*8 +: 8] = 8'h00;
                end
            end
        end
        rem = {slot_reg, 3'b000} + {3'b000, nbytes};
        block_full = (slot_reg == spkh_pkg::LAST_SLOT);
    end

    always_comb
    begin
        fe.wr_en = accept;
        fe.slot = slot_reg;
        fe.commit = accept && (last_word || block_full);
        fe.desc.first = first_reg;
        fe.desc.last_slot = slot_reg;
        fe.desc.rem = rem;
        if (!last_word)
        begin
            fe.desc.kind = spkh_pkg::JOB_MIX;
        end
        else if (rem == spkh_pkg::FULL_BLOCK_BYTES)
        begin
            fe.desc.kind = spkh_pkg::JOB_LAST_FULL;
        end
        else
        begin
            fe.desc.kind = spkh_pkg::JOB_LAST;
        end

        slot_next = slot_reg;
        first_next = first_reg;
        if (accept)
        begin
            if (last_word || block_full)
            begin
                slot_next = 4'd0;
                first_next = last_word;
            end
            else
            begin
                slot_next = slot_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 4'd0;
            first_reg <= 1'b1;
        end
        else
        begin
            slot_reg <= slot_next;
            first_reg <= first_next;
        end
    end

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= spkh_pkg::LAST_SLOT)
        else $error("block word count out of range");

    a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_word) |=> (first_reg && slot_reg == 4'd0))
        else $error("message end did not reopen block state");

endmodule

### design/spkh_queue.sv
// ----------------------------------------------------------------------------
// spkh_queue
// Two-entry block queue between front and back end; the front fills the
// tail entry word by word, the back end reads the head and peeks the next.
// ----------------------------------------------------------------------------
module spkh_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  spkh_pkg::fe_req_t  fe,
    input  spkh_pkg::lane_t    wr_data,
    output logic               tail_free,
    input  spkh_pkg::be_req_t  be,
    output spkh_pkg::q_stat_t  stat,
    output spkh_pkg::lane_t    rd_word,
    output spkh_pkg::block_t   head_block
);

    logic [63:0]       word_mem [2][spkh_pkg::LANE_COUNT];
    spkh_pkg::job_t    desc_reg [2];
    logic [1:0]        valid_reg;
    logic [1:0]        valid_next;
    logic              head_reg;
    logic              tail_reg;

    always_ff @(posedge clk)
    begin
        if (fe.wr_en)
        begin
            word_mem[tail_reg][fe.slot] <= wr_data;
        end
        if (fe.commit)
        begin
            desc_reg[tail_reg] <= fe.desc;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (be.pop)
        begin
            valid_next[head_reg] = 1'b0;
        end
        if (fe.commit)
        begin
            valid_next[tail_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 2'b00;
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (be.pop)
            begin
                head_reg <= !head_reg;
            end
            if (fe.commit)
            begin
                tail_reg <= !tail_reg;
            end
        end
    end

    always_comb
    begin
        tail_free = !valid_reg[tail_reg];
        stat.head_valid = valid_reg[head_reg];
        stat.head_desc = desc_reg[head_reg];
        stat.next_valid = valid_reg[!head_reg];
        stat.next_desc = desc_reg[!head_reg];
        rd_word = word_mem[head_reg ^ be.rd_next][be.rd_slot];
        for (int k = 0; k < spkh_pkg::LANE_COUNT; k++)
        begin
            head_block[k] = word_mem[head_reg][k];
        end
    end

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        be.pop |-> valid_reg[head_reg])
        else $error("pop from empty queue entry");

    a_fill_free: assert property (@(posedge clk) disable iff (!rst_n)
        fe.wr_en |-> !valid_reg[tail_reg])
        else $error("write into a committed queue entry");

endmodule

### design/spkh_back.sv
// ----------------------------------------------------------------------------
// spkh_back
// Lane state and sequencer: seeds lanes, runs one mix step or end step per
// cycle on a rotating lane frame, adds the tail block and emits the digest.
// ----------------------------------------------------------------------------
module spkh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  spkh_pkg::q_stat_t  stat,
    input  spkh_pkg::lane_t    rd_word,
    input  spkh_pkg::block_t   head_block,
    output spkh_pkg::be_req_t  be,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        digest_low,
    output logic [63:0]        digest_high
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MIX,
        ST_TAIL,
        ST_END,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [3:0]        step_reg;
    logic [3:0]        step_next;
    logic [1:0]        round_reg;
    logic [1:0]        round_next;
    spkh_pkg::block_t  lane_reg;
    spkh_pkg::block_t  lane_next;
    spkh_pkg::lane_t   pre_reg;
    spkh_pkg::lane_t   pre_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [63:0]       digest_low_reg;
    logic [63:0]       digest_high_reg;
    logic              load_out;
    logic [63:0]       seed_low_reg;
    logic [63:0]       seed_high_reg;

    spkh_pkg::block_t  seed_lanes;
    spkh_pkg::block_t  base;
    spkh_pkg::block_t  tail;
    spkh_pkg::block_t  mix_u;
    spkh_pkg::block_t  end_u;
    spkh_pkg::block_t  mix_lanes;
    spkh_pkg::block_t  end_lanes;
    spkh_pkg::job_t    head;
    spkh_pkg::job_t    next;
    logic              last_step;
    logic              chain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_low_reg <= '0;
            seed_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == spkh_pkg::REG_SEED_LOW)
            begin
                seed_low_reg <= cfg_data;
            end
            if (cfg_index == spkh_pkg::REG_SEED_HIGH)
            begin
                seed_high_reg <= cfg_data;
            end
        end
    end

    // datapath for one step; frame shifts by one lane each step
    always_comb
    begin
        head = stat.head_desc;
        next = stat.next_desc;
        seed_lanes = {4{spkh_pkg::SEED_CONST, seed_high_reg, seed_low_reg}};
        base = head.first ? seed_lanes : lane_reg;

        for (int k = 0; k < spkh_pkg::LANE_COUNT; k++)
        begin
            tail[k] = (4'(k) <= head.last_slot) ? head_block[k] : 64'd0;
        end
        tail[spkh_pkg::LANE_COUNT-1][63:56] = {1'b0, head.rem};

        mix_u = lane_reg;
        mix_u[2] = lane_reg[2] ^ lane_reg[10];
        mix_u[11] = (lane_reg[11] ^ pre_reg) + lane_reg[1];
        mix_u[0] = spkh_pkg::rotl(pre_reg, spkh_pkg::mix_rot(step_reg));
        mix_lanes = {mix_u[0], mix_u[11:1]};

        end_u = lane_reg;
        end_u[11] = lane_reg[11] + lane_reg[1];
        end_u[2] = lane_reg[2] ^ end_u[11];
        end_u[1] = spkh_pkg::rotl(lane_reg[1], spkh_pkg::end_rot(step_reg));
        end_lanes = {end_u[0], end_u[11:1]};

        last_step = (step_reg == spkh_pkg::LAST_SLOT);
        chain_next = stat.next_valid && (next.kind != spkh_pkg::JOB_LAST) && !next.first;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        round_next = round_reg;
        lane_next = lane_reg;
        pre_next = pre_reg;
        be.pop = 1'b0;
        load_out = 1'b0;
        be.rd_next = (state_reg == ST_MIX) && last_step;
        be.rd_slot = ((state_reg == ST_MIX) && !last_step) ? step_reg + 4'd1 : 4'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.head_valid)
                begin
                    state_next = (head.kind == spkh_pkg::JOB_LAST) ? ST_TAIL : ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                lane_next = base;
                pre_next = base[0] + rd_word;
                step_next = 4'd0;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                lane_next = mix_lanes;
                pre_next = lane_reg[1] + rd_word;
                if (last_step)
                begin
                    be.pop = 1'b1;
                    step_next = 4'd0;
                    round_next = 2'd0;
                    if (head.kind == spkh_pkg::JOB_LAST_FULL)
                    begin
                        state_next = ST_END;
                    end
                    else if (!chain_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_TAIL:
            begin
                for (int k = 0; k < spkh_pkg::LANE_COUNT; k++)
                begin
                    lane_next[k] = base[k] + tail[k];
                end
                be.pop = 1'b1;
                step_next = 4'd0;
                round_next = 2'd0;
                state_next = ST_END;
            end
            ST_END:
            begin
                lane_next = end_lanes;
                if (last_step)
                begin
                    step_next = 4'd0;
                    if (round_reg == 2'd2)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        round_next = round_reg + 2'd1;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !out_ready) || load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= 4'd0;
            round_reg <= 2'd0;
            out_valid_reg <= 1'b0;
            lane_reg <= '0;
            pre_reg <= '0;
            digest_low_reg <= '0;
            digest_high_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            round_reg <= round_next;
            out_valid_reg <= out_valid_next;
            lane_reg <= lane_next;
            pre_reg <= pre_next;
            if (load_out)
            begin
                digest_low_reg <= lane_reg[0];
                digest_high_reg <= lane_reg[1];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign digest_low = digest_low_reg;
    assign digest_high = digest_high_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= spkh_pkg::LAST_SLOT)
        else $error("step counter out of range");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_END) |-> (round_reg != 2'd3))
        else $error("end round counter out of range");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("digest beat raised outside emit");

    a_pop_states: assert property (@(posedge clk) disable iff (!rst_n)
        be.pop |-> (state_reg == ST_MIX || state_reg == ST_TAIL))
        else $error("queue pop outside block processing");

endmodule

### design/spooky_long_path_hash128_unit.sv
// ----------------------------------------------------------------------------
// spooky_long_path_hash128_unit
// 128-bit long-path hash over a stream of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready): one beat per message word; word_data
//   holds eight bytes, first byte in bits 7:0; last_word closes the message,
//   and valid_bytes (saturated at 8) gives the used bytes of that beat only
//   output channel (out_valid/out_ready): one beat per message carrying
//   digest_low (lane 0) and digest_high (lane 1)
//   config port: cfg_write with cfg_index 0 sets seed_low, 1 sets seed_high;
//   seeds are picked up when a message's first block starts in the back end
//   block mixing: the back end mixes a block at one mix step per cycle and
//   chains into the next block only when it is queued by the last mix
//   step, else it passes through its idle and prime states first
//   message end: idle, a tail add, 36 end steps and emit, then out_valid
//   rises; a last word that closes a full block is mixed as a whole block
//   in place of the tail add, and two queued blocks let the front take up
//   to 24 more beats meanwhile
//   reset: seeds clear to zero, queue empties, no message is open
//   receiver stall: the digest waits in the output register, the back end
//   holds in its emit step, the queue fills and in_ready falls
// ----------------------------------------------------------------------------
module spooky_long_path_hash128_unit (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_write,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // word input
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [63:0]  word_data,
    input  logic [3:0]   valid_bytes,
    input  logic         last_word,
    // digest output
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  digest_low,
    output logic [63:0]  digest_high
);

    spkh_pkg::fe_req_t  fe;
    spkh_pkg::lane_t    wr_data;
    spkh_pkg::be_req_t  be;
    spkh_pkg::q_stat_t  stat;
    spkh_pkg::lane_t    rd_word;
    spkh_pkg::block_t   head_block;
    logic               tail_free;
    logic               accept;

    // a beat is taken whenever the tail queue entry is still being filled
    assign in_ready = tail_free;
    assign accept = in_valid && tail_free;

    // front: word masking, block word count, job classification
    spkh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .word_data   (word_data),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .fe          (fe),
        .wr_data     (wr_data)
    );

    // two block entries decouple word intake from lane processing
    spkh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .fe         (fe),
        .wr_data    (wr_data),
        .tail_free  (tail_free),
        .be         (be),
        .stat       (stat),
        .rd_word    (rd_word),
        .head_block (head_block)
    );

    // back: seeding, block mix, tail add, end rounds, digest register
    spkh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stat        (stat),
        .rd_word     (rd_word),
        .head_block  (head_block),
        .be          (be),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_low  (digest_low),
        .digest_high (digest_high)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the long-path 128-bit hash unit: streams messages of
// directed and random lengths, keeps its own model of the hash lanes to
// predict every digest, and checks each digest beat under random stalls.
// ----------------------------------------------------------------------------
module tb;

    // digest prediction and checking
    class digest_scoreboard;

        typedef struct packed {
            spkh_pkg::lane_t lo;
            spkh_pkg::lane_t hi;
        } digest_t;

        int unsigned mix_amt [spkh_pkg::LANE_COUNT] =
            '{11, 32, 43, 31, 17, 28, 39, 57, 55, 54, 22, 46};
        int unsigned end_amt [spkh_pkg::LANE_COUNT] =
            '{44, 15, 34, 21, 38, 33, 10, 13, 38, 53, 42, 54};

        spkh_pkg::lane_t seed_lo;
        spkh_pkg::lane_t seed_hi;
        spkh_pkg::lane_t lanes [spkh_pkg::LANE_COUNT];
        spkh_pkg::lane_t block [spkh_pkg::LANE_COUNT];
        int unsigned     fill;
        bit              open;
        digest_t         pending_digests [$];

        int unsigned errors;
        int unsigned words;
        int unsigned messages;
        int unsigned checked;
        int unsigned cur_len;
        int unsigned longest;

        function new();
            seed_lo = '0;
            seed_hi = '0;
            fill = 0;
            open = 1'b0;
            errors = 0;
            words = 0;
            messages = 0;
            checked = 0;
            cur_len = 0;
            longest = 0;
            foreach (lanes[i]) lanes[i] = '0;
            foreach (block[i]) block[i] = '0;
        endfunction

        function void set_seed(logic [0:0] idx, spkh_pkg::lane_t value);
            if (idx == spkh_pkg::REG_SEED_LOW)
                seed_lo = value;
            else if (idx == spkh_pkg::REG_SEED_HIGH)
                seed_hi = value;
        endfunction

        function spkh_pkg::lane_t rotate_left(spkh_pkg::lane_t x, int unsigned r);
            r = r % 64;
            if (r == 0)
                return x;
            return (x << r) | (x >> (64 - r));
        endfunction

        function void mix_block();
            for (int i = 0; i < spkh_pkg::LANE_COUNT; i++)
            begin
                lanes[i] += block[i];
                lanes[(i + 2) % 12] ^= lanes[(i + 10) % 12];
                lanes[(i + 11) % 12] ^= lanes[i];
                lanes[i] = rotate_left(lanes[i], mix_amt[i]);
                lanes[(i + 11) % 12] += lanes[(i + 1) % 12];
            end
        endfunction

        function void end_round();
            int a;
            int b;
            int c;
            for (int i = 0; i < spkh_pkg::LANE_COUNT; i++)
            begin
                a = (i + 11) % 12;
                b = (i + 1) % 12;
                c = (i + 2) % 12;
                lanes[a] += lanes[b];
                lanes[c] ^= lanes[a];
                lanes[b] = rotate_left(lanes[b], end_amt[i]);
            end
        endfunction

        // one accepted input beat
        function void note_word(spkh_pkg::lane_t word, logic [3:0] nbytes, logic last);
            spkh_pkg::lane_t tail [spkh_pkg::LANE_COUNT];
            int unsigned     nb;
            int unsigned     rem;
            if (!open)
            begin
                for (int i = 0; i < spkh_pkg::LANE_COUNT; i += 3)
                begin
                    lanes[i] = seed_lo;
                    lanes[i + 1] = seed_hi;
                    lanes[i + 2] = spkh_pkg::SEED_CONST;
                end
                fill = 0;
                open = 1'b1;
                messages++;
                cur_len = 0;
            end
            words++;
            cur_len++;
            if (fill >= spkh_pkg::LANE_COUNT)
                fill = 0;
            if (!last)
            begin
                block[fill] = word;
                fill++;
                if (fill == spkh_pkg::LANE_COUNT)
                begin
                    mix_block();
                    fill = 0;
                end
                return;
            end
            nb = (nbytes > 8) ? 8 : nbytes;
            if (nb < 8)
                word = word & ((64'd1 << (8 * nb)) - 64'd1);
            block[fill] = word;
            rem = fill * 8 + nb;
            foreach (tail[i]) tail[i] = '0;
            if (rem == 96)
            begin
                mix_block();
                rem = 0;
            end
            else
            begin
                for (int i = 0; i <= fill; i++)
                    tail[i] = block[i];
            end
            tail[11] = {rem[7:0], tail[11][55:0]};
            for (int i = 0; i < spkh_pkg::LANE_COUNT; i++)
                lanes[i] += tail[i];
            end_round();
            end_round();
            end_round();
            pending_digests.push_back('{lo: lanes[0], hi: lanes[1]});
            fill = 0;
            open = 1'b0;
            if (cur_len > longest)
                longest = cur_len;
        endfunction

        // one accepted digest beat
        function void check_digest(spkh_pkg::lane_t lo, spkh_pkg::lane_t hi);
            digest_t want;
            if (pending_digests.size() == 0)
            begin
                $display("%0t: digest beat with nothing expected: low %h high %h",
                         $time, lo, hi);
                errors++;
                return;
            end
            want = pending_digests.pop_front();
            checked++;
            if (lo !== want.lo)
            begin
                $display("%0t: digest_low mismatch: expected %h actual %h",
                         $time, want.lo, lo);
                errors++;
            end
            if (hi !== want.hi)
            begin
                $display("%0t: digest_high mismatch: expected %h actual %h",
                         $time, want.hi, hi);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_digests.size();
        endfunction

    endclass

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    localparam int SETTLE_CYCLES = 80;
    // long receiver hold-off used to back the unit up into in_ready
    localparam int HOLD_OFF_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] word_data;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    digest_scoreboard sb;

    // idle percentages for each side, changed between phases
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_off_req;

    spooky_long_path_hash128_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .word_data   (word_data),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_low  (digest_low),
        .digest_high (digest_high)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random stalls, or one long hold-off counted here
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // digest beats are taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_digest(digest_low, digest_high);
    end

    // write both seed registers back to back, block idle
    task automatic write_seeds(input spkh_pkg::lane_t lo, input spkh_pkg::lane_t hi);
        cfg_write <= 1'b1;
        cfg_index <= spkh_pkg::REG_SEED_LOW;
        cfg_data  <= lo;
        sb.set_seed(spkh_pkg::REG_SEED_LOW, lo);
        @(negedge clk);
        cfg_index <= spkh_pkg::REG_SEED_HIGH;
        cfg_data  <= hi;
        sb.set_seed(spkh_pkg::REG_SEED_HIGH, hi);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // one input beat; entered and left at a falling edge
    task automatic send_word(input spkh_pkg::lane_t data, input logic [3:0] vb,
                             input logic last);
        bit accepted;
        accepted = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        word_data   <= data;
        valid_bytes <= vb;
        last_word   <= last;
        while (!accepted)
        begin
            @(posedge clk);
            if (in_ready)
            begin
                accepted = 1'b1;
                sb.note_word(data, vb, last);
            end
            @(negedge clk);
        end
    endtask

    function automatic spkh_pkg::lane_t pick_word(input fill_t mode);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (mode == FILL_ZERO)
            return '0;
        if (mode == FILL_ONES)
            return '1;
        if (roll < 6)
            return '0;
        if (roll < 12)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // message lengths cluster around block boundaries, with some long ones
    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return $urandom_range(1, 3);
        if (roll < 45)
            return $urandom_range(11, 13);
        if (roll < 70)
            return $urandom_range(4, 24);
        if (roll < 92)
            return $urandom_range(23, 37);
        return $urandom_range(38, 60);
    endfunction

    // mostly legal byte counts, sometimes the saturating ones
    function automatic logic [3:0] pick_last_bytes();
        if ($urandom_range(0, 99) < 75)
            return 4'($urandom_range(0, 8));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic send_message(input int unsigned nwords, input logic [3:0] last_vb,
                                input fill_t mode);
        for (int k = 1; k < nwords; k++)
            send_word(pick_word(mode), 4'($urandom_range(0, 15)), 1'b0);
        send_word(pick_word(mode), last_vb, 1'b1);
    endtask

    task automatic random_messages(input int unsigned target);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < target)
        begin
            len = pick_length();
            send_message(len, pick_last_bytes(), FILL_RANDOM);
            sent += len;
        end
    endtask

    // wait for every digest, then let the back end settle before config
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = spkh_pkg::REG_SEED_LOW;
        cfg_data      = '0;
        in_valid      = 1'b0;
        word_data     = '0;
        valid_bytes   = '0;
        last_word     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b0;
        sb = new();

        // hold reset, then release it on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: zero seeds, the corner cases of the last word
        write_seeds('0, '0);
        send_idle_pct = 12;
        recv_idle_pct = 64;
        send_message(1, 4'd0, FILL_ONES);       // empty message, all bytes masked
        send_message(1, 4'd8, FILL_ONES);       // one full word
        send_message(1, 4'd15, FILL_ONES);      // byte count saturates to 8
        send_message(1, 4'd8, FILL_ZERO);
        send_message(1, 4'd4, FILL_RANDOM);
        send_message(2, 4'd3, FILL_RANDOM);
        send_message(12, 4'd8, FILL_RANDOM);    // last word closes a full block
        drain();

        // random, all-ones seeds, sender idles a little and receiver a lot
        write_seeds('1, '1);
        random_messages(220);
        drain();

        // random seeds, roles swapped
        write_seeds({$urandom, $urandom}, {$urandom, $urandom});
        send_idle_pct = 64;
        recv_idle_pct = 12;
        random_messages(220);
        drain();

        // mixed seeds, no idling; receiver holds off long at the start so the
        // queue fills and in_ready drops while words keep coming
        write_seeds('1, {$urandom, $urandom});
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        random_messages(240);
        drain();

        $display("covered %0d words in %0d messages (longest %0d words), %0d digests checked",
                 sb.words, sb.messages, sb.longest, sb.checked);
        $display("seeds zero, all-ones and random; last-word byte counts 0..15; long stall");
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
design/spkh_pkg.sv
design/spkh_front.sv
design/spkh_queue.sv
design/spkh_back.sv
design/spooky_long_path_hash128_unit.sv
bench/tb.sv
